FILE: rtl/core/rpm_pkg.sv
// ----------------------------------------------------------------------------
// rpm_pkg
// Shared constants, word types and control structs of the RMS / peak level
// meter.
// ----------------------------------------------------------------------------
package rpm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 32;

    // Output field widths are fixed by the word format.
    localparam int LEVEL_W = 16;
    localparam int TALLY_W = 32;

    localparam int MAG_W  = SAMPLE_BITS;
    localparam int PROD_W = 2 * SAMPLE_BITS;

    // Largest sum that can build up before the tally saturates; capped at 64
    // bits, where the sum saturates instead.
    localparam int SUM_FULL_W = 2 * (SAMPLE_BITS - 1) + COUNT_BITS;
    localparam int SUM_W      = (SUM_FULL_W > 64) ? 64 : SUM_FULL_W;

    // Root width and the even-width radicand / dividend register.
    localparam int SQ_W  = (SUM_W + 1) / 2;
    localparam int X_W   = 2 * SQ_W;
    localparam int CNT_W = $clog2(X_W);

    localparam int RMS_EXT_W  = (SQ_W > LEVEL_W) ? SQ_W : LEVEL_W;
    localparam int PEAK_EXT_W = (MAG_W > LEVEL_W) ? MAG_W : LEVEL_W;

    localparam logic [COUNT_BITS-1:0] TALLY_MAX = '1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] sample;
    } in_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] rms_level;
        logic [LEVEL_W-1:0] peak_level;
        logic [TALLY_W-1:0] samples_seen;
        logic               count_saturated;
    } out_word_t;

    typedef struct packed {
        logic capture;
        logic square;
        logic accum;
        logic report;
        logic div_step;
        logic sqrt_step;
        logic load_out;
    } rpm_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic step_last;
    } rpm_status_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SQUARE = 6'b000010,
        ST_ACCUM  = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_SQRT   = 6'b010000,
        ST_RESULT = 6'b100000
    } rpm_state_t;

endpackage

FILE: rtl/core/rpm_datapath.sv
// ----------------------------------------------------------------------------
// rpm_datapath
// Accumulators, square unit, bit-serial divider and square root, and the
// output word register.
// ----------------------------------------------------------------------------
module rpm_datapath
    import rpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_word_t    in_data,
    input  rpm_cmd_t    cmd,
    output rpm_status_t status,
    output out_word_t   out_data
);

    // running accumulators
    logic [SUM_W-1:0]      sum_reg;
    logic [MAG_W-1:0]      peak_reg;
    logic [COUNT_BITS-1:0] tally_reg;
    logic                  ovf_reg;

    // sample pipeline
    logic [MAG_W-1:0]  mag_reg;
    logic [PROD_W-1:0] sq_reg;

    // report working set
    logic [COUNT_BITS-1:0] den_reg;
    logic [MAG_W-1:0]      snap_peak_reg;
    logic                  snap_ovf_reg;
    logic [X_W-1:0]        x_reg;
    logic [COUNT_BITS:0]   div_rem_reg;
    logic [SQ_W+1:0]       sq_rem_reg;
    logic [SQ_W-1:0]       root_reg;
    logic [CNT_W-1:0]      cnt_reg;

    out_word_t out_reg;

    logic [SAMPLE_BITS-1:0] raw;
    logic [MAG_W-1:0]       mag;
    logic [SUM_W:0]         sum_add;
    logic                   tally_full;
    logic [COUNT_BITS:0]    div_trial;
    logic                   div_ge;
    logic [SQ_W+1:0]        sq_trial;
    logic [SQ_W+1:0]        sq_sub;
    logic                   sq_ge;
    logic [RMS_EXT_W-1:0]   rms_ext;
    logic [PEAK_EXT_W-1:0]  peak_ext;

    assign raw = SAMPLE_BITS'(in_data.sample);
    assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

    assign sum_add    = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
    assign tally_full = (tally_reg == TALLY_MAX);

    // restoring divide: one quotient bit per cycle, shifted into x_reg
    assign div_trial = {div_rem_reg[COUNT_BITS-1:0], x_reg[X_W-1]};
    assign div_ge    = (div_trial >= {1'b0, den_reg});

    // digit-by-digit root: two radicand bits per cycle
    assign sq_trial = {sq_rem_reg[SQ_W-1:0], x_reg[X_W-1:X_W-2]};
    assign sq_sub   = {root_reg, 2'b01};
    assign sq_ge    = (sq_trial >= sq_sub);

    assign rms_ext  = RMS_EXT_W'(root_reg);
    assign peak_ext = PEAK_EXT_W'(snap_peak_reg);

    assign status.den_zero  = (den_reg == '0);
    assign status.step_last = (cnt_reg == '0);

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            peak_reg  <= '0;
            tally_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.report)
        begin
            sum_reg   <= '0;
            peak_reg  <= '0;
            tally_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.accum)
        begin
            if (tally_full)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                sum_reg   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                tally_reg <= tally_reg + 1'b1;
                if (mag_reg > peak_reg)
                begin
                    peak_reg <= mag_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mag_reg <= mag;
        end
        if (cmd.square)
        begin
            sq_reg <= mag_reg * mag_reg;
        end

        if (cmd.report)
        begin
            den_reg       <= tally_reg;
            snap_peak_reg <= peak_reg;
            snap_ovf_reg  <= ovf_reg;
            x_reg         <= X_W'(sum_reg);
            div_rem_reg   <= '0;
            sq_rem_reg    <= '0;
            root_reg      <= '0;
            cnt_reg       <= CNT_W'(X_W - 1);
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= div_ge ? (div_trial - {1'b0, den_reg}) : div_trial;
            x_reg       <= {x_reg[X_W-2:0], div_ge};
            cnt_reg     <= status.step_last ? CNT_W'(SQ_W - 1) : cnt_reg - 1'b1;
        end
        else if (cmd.sqrt_step)
        begin
            sq_rem_reg <= sq_ge ? (sq_trial - sq_sub) : sq_trial;
            root_reg   <= {root_reg[SQ_W-2:0], sq_ge};
            x_reg      <= {x_reg[X_W-3:0], 2'b00};
            cnt_reg    <= cnt_reg - 1'b1;
        end

        if (cmd.load_out)
        begin
            out_reg.rms_level       <= rms_ext[LEVEL_W-1:0];
            out_reg.peak_level      <= peak_ext[LEVEL_W-1:0];
            out_reg.samples_seen    <= TALLY_W'(den_reg);
            out_reg.count_saturated <= snap_ovf_reg;
        end
    end

endmodule

FILE: rtl/core/rpm_ctrl.sv
// ----------------------------------------------------------------------------
// rpm_ctrl
// Sequencer of the level meter: input handshake, sample and report steps,
// output valid.
// ----------------------------------------------------------------------------
module rpm_ctrl
    import rpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_cmd,
    output logic        out_valid,
    input  logic        out_ready,
    input  rpm_status_t status,
    output rpm_cmd_t    cmd
);

    rpm_state_t state_reg;
    rpm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd == CMD_REPORT)
                    begin
                        cmd.report = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                // empty report: root stays cleared
                if (status.den_zero)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (status.step_last)
                    begin
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/core/rms_peak_level_meter.sv
// ----------------------------------------------------------------------------
// rms_peak_level_meter
// Audio level meter: squared-sample sum, peak magnitude and sample count,
// reported as floor RMS, peak, count and saturation flag.
// ----------------------------------------------------------------------------
// A sample word passes through accept, square and accumulate steps, and
// in_ready stays low while it is squared and accumulated. For a report word
// a restoring divider yields one quotient bit per cycle over the 62-bit sum,
// then a digit-by-digit square root consumes two radicand bits per cycle
// from the same shift register, and in_ready stays low until the result is
// loaded. A report with no samples skips both. A finished report waits in
// the output register, and new samples are accepted while it waits.
module rms_peak_level_meter
    import rpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    rpm_cmd_t    cmd;
    rpm_status_t status;

    rpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (in_data.cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rpm_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

FILE: rtl/core/rpm_checker.sv
// ----------------------------------------------------------------------------
// rpm_checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
module rpm_checker
    import rpm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.cmd == CMD_REPORT) |=> !in_ready)
        else $error("input taken during report computation");

    a_rms_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.rms_level <= out_data.peak_level)
        else $error("rms above peak");

    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.samples_seen == '0) |->
            (out_data.rms_level == '0) && (out_data.peak_level == '0) &&
            !out_data.count_saturated)
        else $error("empty report carries nonzero levels");

    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.count_saturated |->
            out_data.samples_seen == TALLY_W'(TALLY_MAX))
        else $error("saturation flag without full count");

endmodule

bind rms_peak_level_meter rpm_checker u_rpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
